// File: rtl/hns_pkg.sv
// Package for the heightmap neighbourhood smoothing unit.
// Holds widths, register and operation codes, pipeline types and the
// neighbour sum helpers; depends on nothing.
package hns_pkg;

  // Raster geometry
  localparam int MAX_COLUMNS = 1024;
  localparam int ADDR_W      = $clog2(MAX_COLUMNS);
  localparam int COLS_W      = ADDR_W + 1;
  localparam int ROW_W       = 16;

  // Sample and result widths
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 24;
  localparam int FRAC_W   = 8;
  // n * centre + neighbour sum, at most 16 samples
  localparam int NUM_W    = SAMPLE_W + 4;
  // numerator scaled by half of one in fixed point
  localparam int SCALED_W = NUM_W + FRAC_W - 1;

  // Configuration port
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_COLS_W    = 11;
  localparam int CFG_ROWS_W    = 16;
  localparam int RESET_COLUMNS = 256;
  localparam int RESET_ROWS    = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = CFG_IDX_W'(1);

  // Input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    ITEM_NONE,
    ITEM_SAMPLE,
    ITEM_FLUSH
  } item_kind_t;

  typedef enum logic [1:0] {
    DIV_3,
    DIV_5,
    DIV_8
  } divisor_t;

  // Control for one item, decided at acceptance
  typedef struct packed {
    item_kind_t          kind;
    logic                emit_a;
    logic                emit_b;
    logic                up;
    logic                left;
    logic                right;
    logic                last;
    logic [ADDR_W-1:0]   col;
    logic [SAMPLE_W-1:0] x;
  } stage_ctrl_t;

  // Line buffer read data, port a and port b of each buffer
  typedef struct packed {
    logic [SAMPLE_W-1:0] older_a;
    logic [SAMPLE_W-1:0] newer_a;
    logic [SAMPLE_W-1:0] older_b;
    logic [SAMPLE_W-1:0] newer_b;
  } line_rd_t;

  // Line buffer write, shared address for both buffers
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] older_data;
    logic [SAMPLE_W-1:0] newer_data;
  } line_wr_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
    divisor_t         div;
    logic             last;
  } lane_t;

  typedef struct packed {
    lane_t a;
    lane_t b;
  } lane_pair_t;

  typedef struct packed {
    logic [OUT_W-1:0] smoothed_height;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } slot_t;

  typedef logic [8:0][SAMPLE_W-1:0] win9_t;

  // Divisor from the number of in-map neighbours (3, 5 or 8)
  function automatic divisor_t divisor_of(logic [8:0] mask);
    divisor_t d;
    case (4'($countones(mask)))
      4'd8:    d = DIV_8;
      4'd5:    d = DIV_5;
      default: d = DIV_3;
    endcase
    return d;
  endfunction

  // n * centre plus the sum of the masked neighbours
  function automatic logic [NUM_W-1:0] neighbour_num(win9_t w, logic [8:0] mask,
                                                     logic [SAMPLE_W-1:0] centre,
                                                     divisor_t div);
    logic [NUM_W-1:0] acc;
    logic [NUM_W-1:0] c;
    acc = '0;
    c   = NUM_W'(centre);
    for (int i = 0; i < 9; i++) begin
      if (mask[i]) begin
        acc = acc + NUM_W'(w[i]);
      end
    end
    case (div)
      DIV_8:   acc = acc + (c << 3);
      DIV_5:   acc = acc + (c << 2) + c;
      default: acc = acc + (c << 1) + c;
    endcase
    return acc;
  endfunction

endpackage

// File: rtl/hns_if.sv
// Channel interfaces of the smoothing unit: raster input, smoothed result
// and configuration write. Depends on hns_pkg.

interface hns_raster_if;
  import hns_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [SAMPLE_W-1:0] height_sample;
  modport source (output valid, op, height_sample, input ready);
  modport sink   (input valid, op, height_sample, output ready);
endinterface

interface hns_result_if;
  import hns_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] smoothed_height;
  logic             frame_last;
  modport source (output valid, smoothed_height, frame_last, input ready);
  modport sink   (input valid, smoothed_height, frame_last, output ready);
endinterface

interface hns_cfg_if;
  import hns_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/hns_ram.sv
// Generic RAM: one write port, two registered read ports, write-first on
// an address clash. Depends on nothing.
module hns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads; pass new data through on a clash
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
      rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
    end
  end

endmodule

// File: rtl/hns_ctrl.sv
// Acceptance stage: configuration registers, raster position tracking and
// drain control, line buffer read addressing. Depends on hns_pkg, hns_if.
module hns_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  hns_raster_if.sink                 raster,
  hns_cfg_if.sink                    cfg,
  input  logic                       adv,
  output hns_pkg::stage_ctrl_t       s1,
  output logic [hns_pkg::ADDR_W-1:0] rd_addr_a,
  output logic [hns_pkg::ADDR_W-1:0] rd_addr_b
);
  import hns_pkg::*;

  logic [CFG_COLS_W-1:0] map_columns;
  logic [CFG_ROWS_W-1:0] map_rows;
  logic [ADDR_W-1:0]     col_pos;
  logic [ADDR_W-1:0]     col_pos_next;
  logic [ADDR_W-1:0]     flush_pos;
  logic [ADDR_W-1:0]     flush_pos_next;
  logic [ROW_W-1:0]      row_pos;
  logic [ROW_W-1:0]      row_pos_next;
  logic                  draining;
  logic                  draining_next;
  logic [COLS_W-1:0]     cols_eff;
  logic [ROW_W-1:0]      rows_eff;
  logic                  accept;
  logic                  last_col;
  logic                  last_row;
  logic                  flush_last;
  stage_ctrl_t           item;

  // Take no transfer while in reset
  assign raster.ready = adv & ~rst;
  assign cfg.ready    = ~rst;
  assign accept       = raster.valid & adv;

  // Clamp the configured geometry
  always_comb begin
    if (map_columns < 2) begin
      cols_eff = COLS_W'(2);
    end else if (map_columns > MAX_COLUMNS) begin
      cols_eff = COLS_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COLS_W'(map_columns);
    end
  end

  assign rows_eff   = (map_rows < 2) ? ROW_W'(2) : ROW_W'(map_rows);
  assign last_col   = COLS_W'(col_pos) >= cols_eff - COLS_W'(1);
  assign flush_last = COLS_W'(flush_pos) >= cols_eff - COLS_W'(1);
  assign last_row   = row_pos >= rows_eff - ROW_W'(1);

  // Port a serves the sample column or the drain column, port b the column after the drain column
  assign rd_addr_a = draining ? flush_pos : col_pos;
  assign rd_addr_b = flush_pos + ADDR_W'(1);

  // Classify the transfer and advance the raster position
  always_comb begin
    item           = '0;
    item.kind      = ITEM_NONE;
    item.col       = col_pos;
    item.x         = raster.height_sample;
    col_pos_next   = col_pos;
    row_pos_next   = row_pos;
    flush_pos_next = flush_pos;
    draining_next  = draining;
    if (accept) begin
      if (raster.op == OP_FLUSH) begin
        if (draining) begin
          item.kind  = ITEM_FLUSH;
          item.left  = flush_pos != '0;
          item.right = !flush_last;
          item.last  = flush_last;
          if (flush_last) begin
            draining_next  = 1'b0;
            flush_pos_next = '0;
          end else begin
            flush_pos_next = flush_pos + ADDR_W'(1);
          end
        end
      end else if (!draining) begin
        item.kind   = ITEM_SAMPLE;
        item.up     = row_pos >= ROW_W'(2);
        item.left   = COLS_W'(col_pos) >= COLS_W'(2);
        item.emit_a = (row_pos != '0) && (col_pos != '0);
        item.emit_b = (row_pos != '0) && last_col;
        if (last_col) begin
          col_pos_next = '0;
          if (last_row) begin
            row_pos_next   = '0;
            draining_next  = 1'b1;
            flush_pos_next = '0;
          end else begin
            row_pos_next = row_pos + ROW_W'(1);
          end
        end else begin
          col_pos_next = col_pos + ADDR_W'(1);
        end
      end
    end
  end

  // Hold configuration, positions and the stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      map_columns <= CFG_COLS_W'(RESET_COLUMNS);
      map_rows    <= CFG_ROWS_W'(RESET_ROWS);
      col_pos     <= '0;
      row_pos     <= '0;
      flush_pos   <= '0;
      draining    <= 1'b0;
      s1.kind     <= ITEM_NONE;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_MAP_COLUMNS: map_columns <= cfg.data[CFG_COLS_W-1:0];
          CFG_MAP_ROWS:    map_rows    <= cfg.data[CFG_ROWS_W-1:0];
          default: ;
        endcase
      end
      col_pos   <= col_pos_next;
      row_pos   <= row_pos_next;
      flush_pos <= flush_pos_next;
      draining  <= draining_next;
      if (adv) begin
        s1 <= item;
      end
    end
  end

endmodule

// File: rtl/hns_window.sv
// Window stage: 3x3 sample window, line buffer write-back and the
// neighbour numerators of up to two results. Depends on hns_pkg.
module hns_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  hns_pkg::stage_ctrl_t s1,
  input  hns_pkg::line_rd_t    rd,
  output hns_pkg::line_wr_t    wr,
  output hns_pkg::lane_pair_t  s2
);
  import hns_pkg::*;

  win9_t               win;
  win9_t               shifted;
  win9_t               flush_win;
  win9_t               win_a;
  logic [SAMPLE_W-1:0] prev_older;
  logic [SAMPLE_W-1:0] prev_newer;
  logic                is_sample;
  logic                is_flush;
  logic [8:0]          mask_a;
  logic [8:0]          mask_b;
  logic [8:0]          mask_f;
  logic [8:0]          mask_sel;
  divisor_t            div_a;
  divisor_t            div_b;
  lane_pair_t          lanes;

  assign is_sample = s1.kind == ITEM_SAMPLE;
  assign is_flush  = s1.kind == ITEM_FLUSH;

  // Shift the window left and bring in the new column
  always_comb begin
    shifted = win;
    for (int i = 0; i < 3; i++) begin
      shifted[i*3]     = win[i*3+1];
      shifted[i*3+1]   = win[i*3+2];
    end
    shifted[2] = rd.older_a;
    shifted[5] = rd.newer_a;
    shifted[8] = s1.x;
  end

  // Drain window: the two stored rows around the drain column, no row below
  always_comb begin
    flush_win    = '0;
    flush_win[0] = prev_older;
    flush_win[1] = rd.older_a;
    flush_win[2] = rd.older_b;
    flush_win[3] = prev_newer;
    flush_win[4] = rd.newer_a;
    flush_win[5] = rd.newer_b;
  end

  // Neighbour masks, bit i*3+d for window row i and column d
  assign mask_a = {1'b1, 1'b1, s1.left, 1'b1, 1'b0, s1.left,
                   s1.up, s1.up, s1.up & s1.left};
  assign mask_b = {1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, s1.up, s1.up, 1'b0};
  assign mask_f = {3'b000, s1.right, 1'b0, s1.left, s1.right, 1'b1, s1.left};

  assign mask_sel = is_flush ? mask_f : mask_a;
  assign win_a    = is_flush ? flush_win : shifted;
  assign div_a    = divisor_of(mask_sel);
  assign div_b    = divisor_of(mask_b);

  // First lane serves the inner pixel or the drain pixel, second the row end
  always_comb begin
    lanes.a.valid = is_flush | (is_sample & s1.emit_a);
    lanes.a.num   = neighbour_num(win_a, mask_sel, win_a[4], div_a);
    lanes.a.div   = div_a;
    lanes.a.last  = is_flush & s1.last;
    lanes.b.valid = is_sample & s1.emit_b;
    lanes.b.num   = neighbour_num(shifted, mask_b, shifted[5], div_b);
    lanes.b.div   = div_b;
    lanes.b.last  = 1'b0;
  end

  // Move the stored row down and store the new sample
  assign wr.we         = adv & is_sample;
  assign wr.addr       = s1.col;
  assign wr.older_data = rd.newer_a;
  assign wr.newer_data = s1.x;

  // Hold window, drain history and the lane register
  always_ff @(posedge clk) begin
    if (rst) begin
      win        <= '0;
      s2.a.valid <= 1'b0;
      s2.b.valid <= 1'b0;
    end else if (adv) begin
      if (is_sample) begin
        win <= shifted;
      end
      if (is_flush) begin
        prev_older <= rd.older_a;
        prev_newer <= rd.newer_a;
      end
      s2 <= lanes;
    end
  end

endmodule

// File: rtl/hns_scale.sv
// Scaling stage: turns each numerator into floor(128 * num / n) with a
// reciprocal multiply for n = 3 and 5 and a shift for n = 8. Depends on hns_pkg.
module hns_scale (
  input  hns_pkg::lane_pair_t s2,
  output hns_pkg::slot_t      slot_a,
  output hns_pkg::slot_t      slot_b
);
  import hns_pkg::*;

  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = RECIP_SHIFT;
  localparam int PROD_W      = SCALED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2 ** RECIP_SHIFT + 3 - 1) / 3);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((2 ** RECIP_SHIFT + 5 - 1) / 5);

  function automatic result_t scale_lane(lane_t l);
    logic [SCALED_W-1:0] x;
    logic [RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]   prod;
    result_t             r;
    x     = {l.num, {(FRAC_W - 1){1'b0}}};
    recip = (l.div == DIV_5) ? RECIP_5 : RECIP_3;
    prod  = PROD_W'(x) * PROD_W'(recip);
    case (l.div)
      DIV_8:   r.smoothed_height = OUT_W'(x >> 3);
      default: r.smoothed_height = prod[RECIP_SHIFT +: OUT_W];
    endcase
    r.frame_last = l.last;
    return r;
  endfunction

  assign slot_a.valid = s2.a.valid;
  assign slot_a.res   = scale_lane(s2.a);
  assign slot_b.valid = s2.b.valid;
  assign slot_b.res   = scale_lane(s2.b);

endmodule

// File: rtl/hns_outq.sv
// Result queue: four entries, takes up to two results a cycle while it has room, and
// hands out one per transfer. Depends on hns_pkg, hns_if.
module hns_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  hns_pkg::slot_t  slot_a,
  input  hns_pkg::slot_t  slot_b,
  output logic            room,
  hns_result_if.source    smoothed
);
  import hns_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  result_t          q [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             push_a;
  logic             push_b;
  logic             pop;
  logic [PTR_W-1:0] tail_b;

  assign push_a = adv & slot_a.valid;
  assign push_b = adv & slot_b.valid;
  assign pop    = smoothed.valid & smoothed.ready;
  assign tail_b = push_a ? tail + PTR_W'(1) : tail;

  // Space for a full pair of results keeps the pipeline moving
  assign room = count <= CNT_W'(DEPTH - 2);

  assign smoothed.valid           = count != '0;
  assign smoothed.smoothed_height = q[head].smoothed_height;
  assign smoothed.frame_last      = q[head].frame_last;

  // Store incoming results in order
  always_ff @(posedge clk) begin
    if (push_a) begin
      q[tail] <= slot_a.res;
    end
    if (push_b) begin
      q[tail_b] <= slot_b.res;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_W'(push_a) + PTR_W'(push_b);
      count <= count + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
      if (pop) begin
        head <= head + PTR_W'(1);
      end
    end
  end

endmodule

// File: rtl/heightmap_neighbor_smoothing_unit.sv
// Top level of the heightmap 3x3 neighbourhood smoothing unit.
// Depends on hns_pkg, hns_if, hns_ram, hns_ctrl, hns_window, hns_scale, hns_outq.
//
//   channel   | direction | payload
//   ----------+-----------+----------------------------------------------
//   raster    | in        | op, height_sample
//   smoothed  | out       | smoothed_height (8 fraction bits), frame_last
//   cfg       | in        | index (0 map_columns, 1 map_rows), data
//
// One raster item is taken per cycle while raster.ready is high. A result
// passes the line buffer read, the window sum register and the scale into
// the result queue. The single result port sets the pace: a row-end sample
// yields two results. raster.ready drops during reset and while the
// four-entry result queue holds three or more.
// Reset clears positions, window and queue; the line buffers are not cleared.
module heightmap_neighbor_smoothing_unit (
  input  logic         clk,
  input  logic         rst,
  hns_raster_if.sink   raster,
  hns_result_if.source smoothed,
  hns_cfg_if.sink      cfg
);
  import hns_pkg::*;

  logic              adv;
  stage_ctrl_t       s1;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  line_rd_t          rd;
  line_wr_t          wr;
  lane_pair_t        s2;
  slot_t             slot_a;
  slot_t             slot_b;

  // Acceptance and position control
  hns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .raster    (raster),
    .cfg       (cfg),
    .adv       (adv),
    .s1        (s1),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b)
  );

  // Line buffers: older row and newer row
  hns_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_older_row (
    .clk     (clk),
    .we      (wr.we),
    .waddr   (wr.addr),
    .wdata   (wr.older_data),
    .re      (adv),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd.older_a),
    .rdata_b (rd.older_b)
  );

  hns_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_newer_row (
    .clk     (clk),
    .we      (wr.we),
    .waddr   (wr.addr),
    .wdata   (wr.newer_data),
    .re      (adv),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd.newer_a),
    .rdata_b (rd.newer_b)
  );

  // Window and neighbour sums
  hns_window u_window (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .s1  (s1),
    .rd  (rd),
    .wr  (wr),
    .s2  (s2)
  );

  // Divide by the neighbour count
  hns_scale u_scale (
    .s2     (s2),
    .slot_a (slot_a),
    .slot_b (slot_b)
  );

  // Result queue; its free space moves the whole pipeline
  hns_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .slot_a   (slot_a),
    .slot_b   (slot_b),
    .room     (adv),
    .smoothed (smoothed)
  );

endmodule

// File: rtl/hns_checker.sv
// Port-level checker for the smoothing unit, bound to the top level.
// Depends on hns_pkg and heightmap_neighbor_smoothing_unit.
module hns_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      raster_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [hns_pkg::OUT_W-1:0] smoothed_height,
  input logic                      frame_last
);

  // Reset empties the result queue
  a_reset_empties: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Input stalls only behind a backlog of results
  a_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    !raster_ready |-> result_valid)
    else $error("raster stalled with no result pending");

  // Without a result transfer the stall cannot clear
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!raster_ready && !(result_valid && result_ready)) |=> !raster_ready)
    else $error("raster stall cleared without a result transfer");

  // A waiting result holds its payload
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(smoothed_height) && $stable(frame_last)))
    else $error("waiting result changed");

endmodule

bind heightmap_neighbor_smoothing_unit hns_checker u_hns_checker (
  .clk             (clk),
  .rst             (rst),
  .raster_ready    (raster.ready),
  .result_valid    (smoothed.valid),
  .result_ready    (smoothed.ready),
  .smoothed_height (smoothed.smoothed_height),
  .frame_last      (smoothed.frame_last)
);

// File: tb/heightmap_neighbor_smoothing_unit_tb.sv
// Self-checking testbench for the heightmap neighbourhood smoothing unit.
// Streams raster frames with random gaps and stalls, predicts every result
// and compares it on transfer. Depends on hns_pkg, hns_if and the unit.
module heightmap_neighbor_smoothing_unit_tb;
  import hns_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 450;
  localparam int QUIET_ITEMS    = 380;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] height;
  } raster_item_t;

  typedef logic [8:0][SAMPLE_W-1:0] window_t;

  logic clk;
  logic rst;

  hns_raster_if raster_bus ();
  hns_result_if result_bus ();
  hns_cfg_if    cfg_bus ();

  heightmap_neighbor_smoothing_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .raster   (raster_bus),
    .smoothed (result_bus),
    .cfg      (cfg_bus)
  );

  // Stimulus and bookkeeping
  raster_item_t raster_items_q[$];
  result_t      due_smoothed_q[$];
  int unsigned  pushed_cnt;
  int unsigned  accepted_cnt;
  int unsigned  mismatch_cnt;
  bit           raster_took;
  int unsigned  src_gap;
  int unsigned  sink_gap;
  int unsigned  src_gap_pct;
  int unsigned  sink_gap_pct;

  // Shadow of the unit: registers, line buffers, window and positions
  logic [CFG_COLS_W-1:0] shadow_cols;
  logic [CFG_ROWS_W-1:0] shadow_rows;
  logic [SAMPLE_W-1:0]   older_line [MAX_COLUMNS];
  logic [SAMPLE_W-1:0]   newer_line [MAX_COLUMNS];
  window_t               window_q;
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           flush_pos;
  bit                    draining;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_cols();
    int unsigned c;
    c = shadow_cols;
    if (c < 2) c = 2;
    if (c > MAX_COLUMNS) c = MAX_COLUMNS;
    return c;
  endfunction

  function automatic int unsigned active_rows();
    int unsigned r;
    r = shadow_rows;
    return (r < 2) ? 2 : r;
  endfunction

  // Half of centre plus neighbour mean, 8 fraction bits, truncated
  function automatic logic [OUT_W-1:0] half_mean(window_t w, int unsigned cc, bit up,
                                                 bit left, bit right, bit down);
    longint unsigned total;
    longint unsigned n;
    longint unsigned centre;
    int unsigned     j;
    total  = 0;
    n      = 0;
    centre = w[3 + cc];
    for (int i = 0; i < 3; i++) begin
      if ((i == 0 && !up) || (i == 2 && !down)) continue;
      for (int d = 0; d < 3; d++) begin
        j = cc + d;
        if (d == 0 && !left) continue;
        if (d == 2 && !right) continue;
        if (i == 1 && d == 1) continue;
        if (j < 1 || j > 3) continue;
        total += w[i * 3 + j - 1];
        n++;
      end
    end
    // no neighbour at all: the centre alone
    if (n == 0) return OUT_W'(centre << 8);
    return OUT_W'((128 * (n * centre + total)) / n);
  endfunction

  // Advance the shadow by one accepted raster item, queue what it yields
  task automatic apply_raster_item(logic op, logic [SAMPLE_W-1:0] x);
    int unsigned ncol;
    int unsigned nrow;
    int unsigned c;
    int unsigned r;
    int unsigned f;
    bit          last_col;
    bit          last;
    window_t     w;
    result_t     res;
    ncol = active_cols();
    nrow = active_rows();
    if (op == OP_FLUSH) begin
      f = flush_pos;
      if (draining && f < MAX_COLUMNS) begin
        w = '0;
        if (f >= 1) begin
          w[0] = older_line[f - 1];
          w[3] = newer_line[f - 1];
        end
        w[1] = older_line[f];
        w[4] = newer_line[f];
        if (f + 1 < ncol) begin
          w[2] = older_line[f + 1];
          w[5] = newer_line[f + 1];
        end
        last = (f >= ncol - 1);
        res.smoothed_height = half_mean(w, 1, 1'b1, f >= 1, !last, 1'b0);
        res.frame_last      = last;
        due_smoothed_q = {due_smoothed_q, res};
        if (last) begin
          draining  = 1'b0;
          flush_pos = 0;
        end else begin
          flush_pos = f + 1;
        end
      end
    end else if (!draining) begin
      c        = col_pos;
      r        = row_pos;
      last_col = (c >= ncol - 1);
      if (c >= MAX_COLUMNS) c = MAX_COLUMNS - 1;
      for (int i = 0; i < 3; i++) begin
        window_q[i * 3]     = window_q[i * 3 + 1];
        window_q[i * 3 + 1] = window_q[i * 3 + 2];
      end
      window_q[2]   = older_line[c];
      window_q[5]   = newer_line[c];
      window_q[8]   = x;
      older_line[c] = newer_line[c];
      newer_line[c] = x;
      res.frame_last = 1'b0;
      if (r >= 1 && c >= 1) begin
        res.smoothed_height = half_mean(window_q, 1, r >= 2, c >= 2, 1'b1, 1'b1);
        due_smoothed_q = {due_smoothed_q, res};
      end
      if (r >= 1 && last_col) begin
        res.smoothed_height = half_mean(window_q, 2, r >= 2, 1'b1, 1'b0, 1'b1);
        due_smoothed_q = {due_smoothed_q, res};
      end
      if (last_col) begin
        col_pos = 0;
        if (r >= nrow - 1) begin
          row_pos   = 0;
          draining  = 1'b1;
          flush_pos = 0;
        end else begin
          row_pos = (r + 1) & 16'hFFFF;
        end
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  task automatic report_mismatch(string what, result_t want, result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) begin
      $display("%0t: %s: expected height %h last %b, got height %h last %b",
               $realtime, what, want.smoothed_height, want.frame_last,
               got.smoothed_height, got.frame_last);
    end
  endtask

  // Driver: raster source and result sink, updated on the falling edge
  always @(negedge clk) begin : driver
    raster_item_t item;
    if (rst) begin
      raster_bus.valid <= 1'b0;
      result_bus.ready <= 1'b0;
    end else begin
      if (!raster_bus.valid || raster_took) begin
        if (src_gap > 0) begin
          src_gap--;
          raster_bus.valid <= 1'b0;
        end else if (raster_items_q.size() > 0) begin
          item = raster_items_q.pop_front();
          raster_bus.valid         <= 1'b1;
          raster_bus.op            <= item.op;
          raster_bus.height_sample <= item.height;
          if ($urandom_range(0, 99) < src_gap_pct) src_gap = $urandom_range(1, 5);
        end else begin
          raster_bus.valid <= 1'b0;
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < sink_gap_pct) sink_gap = $urandom_range(1, 5);
      end
    end
  end

  // Monitor: raster transfers, register writes and result checks on the rising edge
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      raster_took = 1'b0;
    end else begin
      raster_took = raster_bus.valid && raster_bus.ready;
      // a transfer on this edge still sees the old register values
      if (raster_took) begin
        apply_raster_item(raster_bus.op, raster_bus.height_sample);
        accepted_cnt++;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == CFG_MAP_COLUMNS) begin
          shadow_cols = cfg_bus.data[CFG_COLS_W-1:0];
        end else if (cfg_bus.index == CFG_MAP_ROWS) begin
          shadow_rows = cfg_bus.data[CFG_ROWS_W-1:0];
        end
      end
      if (result_bus.valid && result_bus.ready) begin
        got.smoothed_height = result_bus.smoothed_height;
        got.frame_last      = result_bus.frame_last;
        if (due_smoothed_q.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = due_smoothed_q.pop_front();
          if (got.smoothed_height !== want.smoothed_height ||
              got.frame_last !== want.frame_last) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_height();
    case ($urandom_range(0, 3))
      0:       return SAMPLE_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2:       return SAMPLE_W'($urandom_range(0, 255));
      default: return 16'hFF00 | SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_item(logic op, logic [SAMPLE_W-1:0] x);
    raster_item_t item;
    item.op     = op;
    item.height = x;
    raster_items_q = {raster_items_q, item};
    pushed_cnt++;
  endtask

  // Queue whatever completes the current frame and its drain, with optional noise
  task automatic queue_rest_of_frame(int unsigned noise_pct);
    int unsigned ncol;
    int unsigned nrow;
    int unsigned rem_samples;
    int unsigned rem_flushes;
    ncol = active_cols();
    nrow = active_rows();
    if (draining) begin
      rem_samples = 0;
      rem_flushes = ncol - flush_pos;
    end else begin
      rem_samples = ncol - col_pos;
      if (row_pos < nrow - 1) rem_samples += (nrow - 1 - row_pos) * ncol;
      rem_flushes = ncol;
    end
    for (int unsigned i = 0; i < rem_samples; i++) begin
      // a flush with nothing pending is dropped
      if ($urandom_range(0, 99) < noise_pct) queue_item(OP_FLUSH, pick_height());
      queue_item(OP_SAMPLE, pick_height());
    end
    for (int unsigned i = 0; i < rem_flushes; i++) begin
      // a sample during the drain is dropped
      if ($urandom_range(0, 99) < noise_pct) queue_item(OP_SAMPLE, pick_height());
      queue_item(OP_FLUSH, SAMPLE_W'($urandom));
    end
  endtask

  // Wait for every item taken and every result seen, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != pushed_cnt || due_smoothed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gaps();
    case ($urandom_range(0, 3))
      0:       src_gap_pct = 0;
      1:       src_gap_pct = 10;
      default: src_gap_pct = 30;
    endcase
    case ($urandom_range(0, 3))
      0:       sink_gap_pct = 0;
      1:       sink_gap_pct = 10;
      default: sink_gap_pct = 30;
    endcase
  endtask

  // Limit on the whole run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_base;
    int unsigned k;
    int unsigned cols_raw;
    int unsigned len;

    raster_bus.valid         = 1'b0;
    raster_bus.op            = OP_SAMPLE;
    raster_bus.height_sample = '0;
    result_bus.ready         = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = CFG_MAP_COLUMNS;
    cfg_bus.data             = '0;
    pushed_cnt   = 0;
    accepted_cnt = 0;
    mismatch_cnt = 0;
    raster_took  = 1'b0;
    src_gap      = 0;
    sink_gap     = 0;
    src_gap_pct  = 20;
    sink_gap_pct = 20;
    shadow_cols  = CFG_COLS_W'(RESET_COLUMNS);
    shadow_rows  = CFG_ROWS_W'(RESET_ROWS);
    window_q     = '0;
    col_pos      = 0;
    row_pos      = 0;
    flush_pos    = 0;
    draining     = 1'b0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end

    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry, then cut the frame and the row short mid-way
    queue_item(OP_SAMPLE, 16'hFFFF);
    queue_item(OP_SAMPLE, 16'h0000);
    queue_item(OP_SAMPLE, 16'h8001);
    wait_idle();
    write_reg(CFG_MAP_ROWS, 16'h0000);
    write_reg(CFG_MAP_COLUMNS, 16'h0004);
    queue_rest_of_frame(0);
    wait_idle();

    // Smallest map: columns below range, stray flush and stray sample
    write_reg(CFG_MAP_COLUMNS, 16'h0001);
    queue_item(OP_FLUSH, 16'h0000);
    queue_item(OP_SAMPLE, 16'hFFFF);
    queue_item(OP_SAMPLE, 16'h0000);
    queue_item(OP_SAMPLE, 16'hFFFF);
    queue_item(OP_SAMPLE, 16'hFFFF);
    queue_item(OP_SAMPLE, 16'h1234);
    queue_item(OP_FLUSH, 16'hFFFF);
    queue_item(OP_FLUSH, 16'h0000);
    queue_item(OP_FLUSH, 16'h0000);
    wait_idle();

    // 3x3 at full scale: corners, edges and one inner pixel at the maximum
    write_reg(CFG_MAP_COLUMNS, 16'h0003);
    write_reg(CFG_MAP_ROWS, 16'h0003);
    for (int i = 0; i < 9; i++) queue_item(OP_SAMPLE, 16'hFFFF);
    for (int i = 0; i < 3; i++) queue_item(OP_FLUSH, 16'h0000);
    wait_idle();

    // Widest row with columns above range and the tallest frame, then a
    // narrower row and rows below range end the frame early
    write_reg(CFG_MAP_COLUMNS, 16'hFFFF);
    write_reg(CFG_MAP_ROWS, 16'hFFFF);
    for (int i = 0; i < MAX_COLUMNS + 3; i++) queue_item(OP_SAMPLE, pick_height());
    wait_idle();
    write_reg(CFG_MAP_ROWS, 16'h0001);
    write_reg(CFG_MAP_COLUMNS, 16'h0005);
    queue_rest_of_frame(5);
    wait_idle();

    // Index outside the register map: no effect
    write_reg(CFG_SPARE_INDEX, 16'($urandom));

    // Random frames, broken sequences and mid-frame row changes
    random_base = pushed_cnt;
    while (pushed_cnt - random_base < RANDOM_ITEMS) begin
      if (pushed_cnt - random_base >= QUIET_ITEMS) begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end else begin
        set_gaps();
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:       cols_raw = $urandom_range(0, 1);
          1, 2:    cols_raw = $urandom_range(9, 48);
          default: cols_raw = $urandom_range(2, 8);
        endcase
        write_reg(CFG_MAP_COLUMNS, {5'($urandom), 11'(cols_raw)});
      end
      if ($urandom_range(0, 9) < 7) write_reg(CFG_MAP_ROWS, 16'($urandom_range(0, 6)));
      case ($urandom_range(0, 19))
        14, 15, 16: begin
          len = $urandom_range(1, 20);
          for (int unsigned i = 0; i < len; i++) begin
            queue_item($urandom_range(0, 2) == 0 ? OP_FLUSH : OP_SAMPLE, pick_height());
          end
          wait_idle();
        end
        17, 18, 19: begin
          write_reg(CFG_MAP_ROWS, 16'hFFFF);
          k = $urandom_range(1, 3);
          for (int unsigned i = 0; i < k * active_cols(); i++) begin
            queue_item(OP_SAMPLE, pick_height());
          end
          wait_idle();
          write_reg(CFG_MAP_ROWS, 16'($urandom_range(0, k + 3)));
        end
        default: begin
        end
      endcase
      queue_rest_of_frame($urandom_range(0, 15));
      wait_idle();
    end

    // Drain and settle, then give the verdict
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && due_smoothed_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: heightmap_neighbor_smoothing_unit.f
rtl/hns_pkg.sv
rtl/hns_if.sv
rtl/hns_ram.sv
rtl/hns_ctrl.sv
rtl/hns_window.sv
rtl/hns_scale.sv
rtl/hns_outq.sv
rtl/heightmap_neighbor_smoothing_unit.sv
rtl/hns_checker.sv
tb/heightmap_neighbor_smoothing_unit_tb.sv
